// File: hdl/spa_pkg.sv
`default_nettype none

package spa_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_VELOCITY = 2'd1,
      MODE_POSITION = 2'd2,
      MODE_HOLD     = 2'd3
   } mode_type;

   // request kind carried on tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HALF_STEP = 2'd0;
   localparam logic [1:0] CSR_TICK_RATE = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED = 2'd2;

   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [15:0] TICK_RATE_RST = 16'd10000;
   localparam logic [14:0] MAX_SPEED_RST = 15'd1000;

   typedef struct packed {
      logic [31:0] position_out;
      mode_type    current_mode;
      logic        stepped;
      logic        energized;
      logic [3:0]  coils;
   } rsp_type;

   // coil patterns, bit0 = IN1
   localparam logic [3:0] FULL_TABLE [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
   localparam logic [3:0] HALF_TABLE [8] =
      '{4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1};

endpackage : spa_pkg

`default_nettype wire

// File: hdl/stepper_phase_accumulator.sv
`default_nettype none

// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser: op; tdata: cmd_mode, cmd_speed, cmd_target
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: coils, energized, stepped, current_mode,
//         |     |                        |        position_out
// csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
// one request per clock while req_tready is high; each result is registered on rsp.
// all motion state is updated in the accepting cycle by the accumulator adder,
// the position compare and the phase step, so requests may come back to back.
// a result register plus a skid register hold two results; req_tready falls
// only when both are full. csr_ready is always high.
// reset is synchronous, active high; it resets csr and motion state and both valid flags.
module stepper_phase_accumulator
   import spa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] cmd_mode, [17:2] cmd_speed, [49:18] cmd_target, [55:50] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [3:0] coils, [4] energized, [5] stepped, [7:6] current_mode, [39:8] position_out
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_wdata
);

   logic        half_step_ff;
   logic [15:0] tick_rate_ff;
   logic [14:0] max_speed_ff;

   mode_type    mode_ff,     mode_in;
   logic [15:0] speed_ff,    speed_in;
   logic [31:0] target_ff,   target_in;
   logic [31:0] position_ff, position_in;
   logic [16:0] acc_ff,      acc_in;
   logic [2:0]  phase_ff,    phase_in;
   logic        coils_on_ff, coils_on_in;

   rsp_type     result;
   rsp_type     out_ff, skid_ff;
   logic        out_valid_ff, skid_valid_ff;

   logic        accept;
   logic        stepped;

   logic [1:0]  cmd_mode;
   logic [15:0] cmd_speed;
   logic [31:0] cmd_target;

   assign cmd_mode   = req_tdata[1:0];
   assign cmd_speed  = req_tdata[17:2];
   assign cmd_target = req_tdata[49:18];

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_step_ff <= 1'b0;
         tick_rate_ff <= TICK_RATE_RST;
         max_speed_ff <= MAX_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_STEP: half_step_ff <= csr_wdata[0];
            CSR_TICK_RATE: tick_rate_ff <= csr_wdata;
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [16:0] sp;
      logic signed [16:0] lim;
      logic               dir_up;
      logic               moving;
      logic [15:0]        mag;
      logic [16:0]        acc_sum;
      logic [2:0]         ph;

      mode_in     = mode_ff;
      speed_in    = speed_ff;
      target_in   = target_ff;
      position_in = position_ff;
      acc_in      = acc_ff;
      phase_in    = phase_ff;
      coils_on_in = coils_on_ff;
      stepped     = 1'b0;
      dir_up      = 1'b0;
      moving      = 1'b0;
      sp          = {cmd_speed[15], cmd_speed};
      lim         = {2'b00, max_speed_ff};
      mag         = speed_ff[15] ? (16'd0 - speed_ff) : speed_ff;
      acc_sum     = acc_ff + {1'b0, mag};
      ph          = half_step_ff ? phase_ff : {1'b0, phase_ff[1:0]};

      if (req_tuser == OP_CMD) begin
         if (sp < -lim) begin
            sp = -lim;
         end else if (sp > lim) begin
            sp = lim;
         end
         speed_in  = sp[15:0];
         target_in = cmd_target;
         mode_in   = mode_type'(cmd_mode);
         if (mode_type'(cmd_mode) == MODE_IDLE) begin
            acc_in = '0;
         end
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               coils_on_in = 1'b0;
            end
            MODE_POSITION: begin
               coils_on_in = 1'b1;
               if (position_ff == target_ff) begin
                  mode_in = MODE_HOLD;
                  acc_in  = '0;
               end else begin
                  moving = 1'b1;
                  dir_up = $signed(target_ff) > $signed(position_ff);
               end
            end
            MODE_VELOCITY: begin
               coils_on_in = 1'b1;
               if (speed_ff == '0) begin
                  mode_in = MODE_HOLD;
                  acc_in  = '0;
               end else begin
                  moving = 1'b1;
                  dir_up = !speed_ff[15];
               end
            end
            default: begin
               coils_on_in = 1'b1;
            end
         endcase

         // a zero speed in position mode leaves the accumulator alone
         if (moving && (mag != '0)) begin
            acc_in = acc_sum;
            if (acc_sum >= {1'b0, tick_rate_ff}) begin
               acc_in  = acc_sum - {1'b0, tick_rate_ff};
               stepped = 1'b1;
               if (dir_up) begin
                  ph          = ph + 3'd1;
                  position_in = position_ff + 32'd1;
               end else begin
                  ph          = ph - 3'd1;
                  position_in = position_ff - 32'd1;
               end
               // full step wraps within four entries
               phase_in = half_step_ff ? ph : {1'b0, ph[1:0]};
            end
         end
      end
   end

   always_comb begin
      result.position_out = position_in;
      result.current_mode = mode_in;
      result.stepped      = stepped;
      result.energized    = coils_on_in;
      if (!coils_on_in) begin
         result.coils = 4'h0;
      end else if (half_step_ff) begin
         result.coils = HALF_TABLE[phase_in];
      end else begin
         result.coils = FULL_TABLE[phase_in[1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         speed_ff    <= '0;
         target_ff   <= '0;
         position_ff <= '0;
         acc_ff      <= '0;
         phase_ff    <= '0;
         coils_on_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         speed_ff    <= speed_in;
         target_ff   <= target_in;
         position_ff <= position_in;
         acc_ff      <= acc_in;
         phase_ff    <= phase_in;
         coils_on_ff <= coils_on_in;
      end
   end

   // result register with a skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

endmodule : stepper_phase_accumulator

`default_nettype wire

// File: hdl/spa_checker.sv
`default_nettype none

module spa_checker
   import spa_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("buffers not empty after reset");

   // every accepted request has a result waiting in the cycle after
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_energized: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.energized == (rsp.coils != 4'h0)))
      else $error("energized flag disagrees with coil drive");

   a_step_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.stepped |->
         rsp.energized &&
         (rsp.current_mode == MODE_VELOCITY || rsp.current_mode == MODE_POSITION))
      else $error("step reported outside a moving mode");

endmodule : spa_checker

bind stepper_phase_accumulator spa_checker u_spa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/stepper_phase_accumulator_test.sv
`default_nettype none

module stepper_phase_accumulator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   localparam int HOLD_LEN = 60;
   localparam int RANDOM_ITEMS = 1250;
   localparam int PHASE_ITEMS = 160;
   // coil patterns packed a nibble per phase, phase 0 in the low nibble
   localparam logic [31:0] HALF_COILS = 32'h198A_2645;
   localparam logic [15:0] FULL_COILS = 16'h9A65;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [15:0]           csr_wdata = '0;
   wire logic             req_tready;
   wire logic             rsp_tvalid;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;
   wire logic             csr_ready;

   stepper_phase_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // motion state mirrored from the accepted requests
   logic               half_q = 1'b0;
   logic [15:0]        rate_q = TICK_RATE_RST;
   logic [14:0]        max_q = MAX_SPEED_RST;
   mode_type           mode_q = MODE_IDLE;
   logic signed [15:0] speed_q = '0;
   logic signed [31:0] target_q = '0;
   logic signed [31:0] pos_q = '0;
   logic [16:0]        acc_q = '0;
   logic [2:0]         phase_q = '0;
   logic               coils_on_q = 1'b0;

   rsp_type motion_results [$];
   rsp_type got_rsp;
   rsp_type want_rsp;
   int fail_count = 0;
   int result_count = 0;
   int items_sent = 0;
   int steps_predicted = 0;
   int csr_writes = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int unsigned rx_cycle = 0;

   function automatic rsp_type predict_motion(logic op, logic [1:0] m, logic [15:0] sp_raw,
                                              logic [31:0] tgt);
      int sp;
      int lim;
      int unsigned mag;
      int unsigned n;
      int unsigned ph;
      bit moving;
      bit up;
      bit stepped;
      rsp_type r;
      moving = 1'b0;
      up = 1'b0;
      stepped = 1'b0;
      if (op == OP_CMD) begin
         sp = $signed(sp_raw);
         lim = int'(max_q);
         if (sp < -lim) sp = -lim;
         else if (sp > lim) sp = lim;
         speed_q = sp[15:0];
         target_q = tgt;
         mode_q = mode_type'(m);
         if (mode_q == MODE_IDLE) acc_q = '0;
      end else if (mode_q == MODE_IDLE) begin
         coils_on_q = 1'b0;
      end else begin
         coils_on_q = 1'b1;
         case (mode_q)
            MODE_POSITION: begin
               if (pos_q == target_q) begin
                  mode_q = MODE_HOLD;
                  acc_q = '0;
               end else begin
                  moving = 1'b1;
                  up = target_q > pos_q;
               end
            end
            MODE_VELOCITY: begin
               if (speed_q == 0) begin
                  mode_q = MODE_HOLD;
                  acc_q = '0;
               end else begin
                  moving = 1'b1;
                  up = speed_q > 0;
               end
            end
            default: ;
         endcase
         sp = speed_q;
         mag = (sp < 0) ? -sp : sp;
         if (moving && mag != 0) begin
            acc_q = 17'(acc_q + mag);
            if (acc_q >= rate_q) begin
               acc_q = 17'(acc_q - rate_q);
               n = half_q ? 8 : 4;
               ph = phase_q % n;
               ph = up ? (ph + 1) % n : (ph + n - 1) % n;
               phase_q = ph[2:0];
               pos_q = up ? pos_q + 1 : pos_q - 1;
               stepped = 1'b1;
            end
         end
      end
      if (!coils_on_q) r.coils = 4'h0;
      else if (half_q) r.coils = HALF_COILS[phase_q*4 +: 4];
      else r.coils = FULL_COILS[phase_q[1:0]*4 +: 4];
      r.energized = coils_on_q;
      r.stepped = stepped;
      r.current_mode = mode_q;
      r.position_out = pos_q;
      return r;
   endfunction

   task automatic send_request(logic op, logic [1:0] m, logic [15:0] sp, logic [31:0] tgt);
      int gap;
      rsp_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tuser <= op;
      req_tdata <= {6'b0, tgt, sp, m};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      want = predict_motion(op, m, sp, tgt);
      motion_results.push_back(want);
      items_sent++;
      if (want.stepped) steps_predicted++;
   endtask

   // tick fields other than op are don't-care, so they carry noise
   task automatic send_ticks(int count);
      repeat (count) send_request(OP_TICK, 2'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (motion_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_HALF_STEP: half_q = val[0];
         CSR_TICK_RATE: rate_q = val;
         CSR_MAX_SPEED: max_q = val[14:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic half, logic [15:0] rate, logic [14:0] max_spd);
      wait_results_done();
      write_register(CSR_HALF_STEP, {15'b0, half});
      write_register(CSR_TICK_RATE, rate);
      write_register(CSR_MAX_SPEED, {1'b0, max_spd});
   endtask

   task automatic report_mismatch(string field, longint unsigned got_v, longint unsigned want_v);
      $display("mismatch in %s of result %0d: got %0h, expected %0h",
               field, result_count, got_v, want_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got_rsp = rsp_type'(rsp_tdata);
         if (motion_results.size() == 0) begin
            report_mismatch("result with no request waiting", rsp_tdata, 0);
         end else begin
            want_rsp = motion_results.pop_front();
            if (got_rsp.coils !== want_rsp.coils)
               report_mismatch("coils", got_rsp.coils, want_rsp.coils);
            if (got_rsp.energized !== want_rsp.energized)
               report_mismatch("energized", got_rsp.energized, want_rsp.energized);
            if (got_rsp.stepped !== want_rsp.stepped)
               report_mismatch("stepped", got_rsp.stepped, want_rsp.stepped);
            if (got_rsp.current_mode !== want_rsp.current_mode)
               report_mismatch("current_mode", got_rsp.current_mode, want_rsp.current_mode);
            if (got_rsp.position_out !== want_rsp.position_out)
               report_mismatch("position_out", got_rsp.position_out, want_rsp.position_out);
         end
         result_count++;
      end
   end

   // receiver: rotating stall patterns, plus a long hold-off on request
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((rx_cycle >> 8) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic test_defaults_and_clamp();
      send_ticks(1);
      send_request(OP_CMD, MODE_VELOCITY, 16'h7FFF, 32'h7FFF_FFFF);
      send_ticks(1);
      send_request(OP_CMD, MODE_HOLD, 16'h8000, 32'h8000_0000);
      send_ticks(1);
      send_request(OP_CMD, MODE_IDLE, 16'h0000, 32'h0000_0000);
      send_ticks(1);
   endtask

   // threshold 1 with full speed grows the accumulator until it wraps,
   // stepping backward below zero
   task automatic test_accumulator_wrap();
      set_config(1'b0, 16'd1, 15'h7FFF);
      send_request(OP_CMD, MODE_VELOCITY, 16'h8000, 32'hFFFF_FFFF);
      send_ticks(6);
      send_request(OP_CMD, MODE_VELOCITY, 16'h0000, 32'h0);
      send_ticks(1);
   endtask

   task automatic test_zero_threshold_half_step();
      set_config(1'b1, 16'd0, 15'h7FFF);
      send_request(OP_CMD, MODE_POSITION, 16'd3, 32'hFFFF_FFFE);
      send_ticks(4);
   endtask

   // half-step index of 4 or more folds back into the full-step table
   task automatic test_table_fold();
      set_config(1'b0, 16'd1, 15'h7FFF);
      send_request(OP_CMD, MODE_VELOCITY, 16'd1, 32'h0);
      send_ticks(2);
   endtask

   task automatic test_zero_speed_limit();
      set_config(1'b0, 16'd1, 15'd0);
      send_request(OP_CMD, MODE_VELOCITY, 16'hFFFB, 32'h0);
      send_ticks(1);
      send_request(OP_CMD, MODE_POSITION, 16'd7, 32'd100);
      send_ticks(1);
      send_request(OP_CMD, MODE_IDLE, 16'h0, 32'h0);
      send_ticks(1);
   endtask

   task automatic test_backpressure();
      set_config(1'b1, 16'd4, 15'h7FFF);
      send_request(OP_CMD, MODE_VELOCITY, 16'd3, 32'h0);
      gaps_on = 1'b0;
      hold_token <= hold_token + 1;
      send_ticks(40);
      wait_results_done();
      gaps_on = 1'b1;
   endtask

   task automatic random_command(bit noise);
      logic [1:0]  m;
      logic [15:0] sp;
      logic [31:0] tgt;
      int pick;
      if (noise) begin
         send_request(OP_CMD, 2'($urandom), 16'($urandom), $urandom);
      end else begin
         pick = $urandom_range(0, 9);
         if (pick == 0) m = MODE_IDLE;
         else if (pick == 1) m = MODE_HOLD;
         else if (pick < 6) m = MODE_VELOCITY;
         else m = MODE_POSITION;
         case ($urandom_range(0, 3))
            0: sp = 16'($urandom);
            1: sp = 16'($urandom_range(0, 600) - 300);
            2: sp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: sp = 16'($urandom_range(0, 40) - 20);
         endcase
         if ($urandom_range(0, 3) != 0) tgt = pos_q + $urandom_range(0, 60) - 30;
         else tgt = $urandom;
         send_request(OP_CMD, m, sp, tgt);
      end
   endtask

   task automatic test_random_motion();
      int start;
      int phase_start;
      int run;
      logic [15:0] rate;
      logic [14:0] max_spd;
      bit first;
      start = items_sent;
      first = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (first) begin
            set_config(1'b1, 16'hFFFF, 15'h7FFF);
            first = 1'b0;
         end else begin
            case ($urandom_range(0, 4))
               0: rate = 16'd1;
               1: rate = 16'hFFFF;
               2: rate = 16'($urandom_range(1, 64));
               3: rate = 16'($urandom_range(1, 2000));
               default: rate = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 4))
               0: max_spd = 15'd0;
               1: max_spd = 15'h7FFF;
               2: max_spd = 15'($urandom_range(1, 200));
               default: max_spd = 15'($urandom_range(0, 32767));
            endcase
            set_config(1'($urandom_range(0, 1)), rate, max_spd);
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            random_command($urandom_range(0, 9) == 0);
            run = $urandom_range(5, 60);
            repeat (run) begin
               if ($urandom_range(0, 19) == 0) random_command($urandom_range(0, 1));
               else send_ticks(1);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_and_clamp();
      test_accumulator_wrap();
      test_zero_threshold_half_step();
      test_table_fold();
      test_zero_speed_limit();
      test_backpressure();
      test_random_motion();
      wait_results_done();
      repeat (8) @(posedge clock);
      $display("%0d requests checked against %0d results, %0d predicted steps",
               items_sent, result_count, steps_predicted);
      $display("%0d register writes across full-step and half-step tables", csr_writes);
      if (fail_count == 0) begin
         $display("stepper_phase_accumulator_test OK");
      end else begin
         $display("stepper_phase_accumulator_test NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", motion_results.size());
      $display("stepper_phase_accumulator_test NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
